// ----- sv/espc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and register codes for the encoder speed P controller.
// Depends on nothing; every other file refers to it by scoped names.
package espc_pkg;

    // Scaling constants of the knob and motor encoders
    localparam int KNOB_STEPS        = 40;
    localparam int FULL_SPEED_COUNTS = 400;

    // Field widths
    localparam int COUNT_W    = 32;
    localparam int KNOB_W     = 16;
    localparam int GAIN_W     = 16;
    localparam int PERIOD_W   = 17;
    localparam int BAND_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND   = 2'd2;

    // Item kinds
    localparam logic CMD_SPEED   = 1'b0;
    localparam logic CMD_CONTROL = 1'b1;

    // Register reset values
    localparam logic [GAIN_W-1:0]   GAIN_RESET   = 16'd3277;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 17'd1001;
    localparam logic [BAND_W-1:0]   BAND_RESET   = 16'd4;

    // Knob delta after clamping, and the target sum before saturation
    localparam int DELTA_W   = $clog2(KNOB_STEPS + 1) + 1;
    localparam int TGT_SUM_W = KNOB_W + 1;
    localparam logic signed [KNOB_W-1:0]  KNOB_HI   = KNOB_W'(KNOB_STEPS);
    localparam logic signed [KNOB_W-1:0]  KNOB_LO   = KNOB_W'(-KNOB_STEPS);
    localparam logic signed [DELTA_W-1:0] DELTA_MAX = DELTA_W'(KNOB_STEPS);
    localparam logic signed [DELTA_W-1:0] DELTA_MIN = DELTA_W'(-KNOB_STEPS);

    // Error numerator: target * FULL_SPEED_COUNTS - speed * KNOB_STEPS
    localparam int TP_W  = KNOB_W + $clog2(FULL_SPEED_COUNTS + 1);
    localparam int SP_W  = COUNT_W + $clog2(KNOB_STEPS + 1);
    localparam int NUM_W = ((TP_W > SP_W) ? TP_W : SP_W) + 1;
    localparam logic signed [TP_W-1:0] FSC_MULT = TP_W'(FULL_SPEED_COUNTS);
    localparam logic signed [SP_W-1:0] KS_MULT  = SP_W'(KNOB_STEPS);

    // Serial divider: (mag << FRAC_W) / (KNOB_STEPS * FULL_SPEED_COUNTS)
    localparam int FRAC_W    = 16;
    localparam int DENOM     = KNOB_STEPS * FULL_SPEED_COUNTS;
    localparam int REM_W     = $clog2(DENOM);
    localparam int DIVD_W    = NUM_W + FRAC_W;
    localparam int DIV_CNT_W = $clog2(DIVD_W);
    localparam logic [REM_W:0] DENOM_V = (REM_W + 1)'(DENOM);

    // Serial multiplier: 32-bit multiplicand, period-wide multiplier
    localparam int QUOT_W    = 32;
    localparam int MCAND_W   = QUOT_W;
    localparam int MPLIER_W  = PERIOD_W;
    localparam int PROD_W    = MCAND_W + MPLIER_W;
    localparam int MUL_CNT_W = $clog2(MPLIER_W);

    typedef struct packed {
        logic               command;
        logic [COUNT_W-1:0] counter_value;
    } in_item_t;

    typedef struct packed {
        logic [PERIOD_W-1:0]      compare_value;
        logic                     direction;
        logic signed [KNOB_W-1:0] target_steps;
    } out_item_t;

    typedef struct packed {
        logic done;
        logic ovf;
    } div_status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KNOB,
        ST_TARGET,
        ST_SCALE,
        ST_DIFF,
        ST_ABS,
        ST_DIV_GO,
        ST_DIV,
        ST_GAIN,
        ST_PER_GO,
        ST_PER,
        ST_OUT
    } state_t;

endpackage

// ----- sv/encoder_speed_p_controller.sv -----
`timescale 1ns / 1ps
// Top level of the encoder speed P controller: sequencer, state and output register.
// Depends on espc_pkg, espc_div and espc_mul.
//
//   channel   ports                          payload      direction
//   input     s_valid / s_ready / s_data     in_item_t    in
//   result    m_valid / m_ready / m_data     out_item_t   out
//   config    cfg_we / cfg_index / cfg_wdata raw write    in
//
// A speed sample is taken in the idle state and gives no result.
// A control step holds s_ready low while it runs: the setup states ST_KNOB to ST_DIV_GO,
// the bit-serial divider and its done flag, the two passes of the shared multiplier
// (gain, then period), a state to start the second pass and one to load the result.
// The result register lets the next item in while a result waits; a new result
// stalls in the last state until m_ready frees the register.
// Reset is synchronous: state clears to zero, config and controller state take defaults.
module encoder_speed_p_controller (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  espc_pkg::in_item_t                s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output espc_pkg::out_item_t               m_data,
    input  logic                              cfg_we,
    input  logic [espc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [espc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    espc_pkg::state_t state_reg, state_next;

    // Configuration
    logic [espc_pkg::GAIN_W-1:0]    gain_reg, gain_next;
    logic [espc_pkg::PERIOD_W-1:0]  period_reg, period_next;
    logic [espc_pkg::BAND_W-1:0]    band_reg, band_next;

    // Controller state
    logic [espc_pkg::COUNT_W-1:0]         last_motor_reg, last_motor_next;
    logic [espc_pkg::KNOB_W-1:0]          last_knob_reg, last_knob_next;
    logic signed [espc_pkg::COUNT_W-1:0]  speed_reg, speed_next;
    logic signed [espc_pkg::KNOB_W-1:0]   target_reg, target_next;

    // Working registers of one control step
    logic [espc_pkg::KNOB_W-1:0]          knob_in_reg, knob_in_next;
    logic signed [espc_pkg::DELTA_W-1:0]  delta_reg, delta_next;
    logic signed [espc_pkg::TP_W-1:0]     prod_t_reg, prod_t_next;
    logic signed [espc_pkg::SP_W-1:0]     prod_s_reg, prod_s_next;
    logic [espc_pkg::COUNT_W-1:0]         spd_mag_reg, spd_mag_next;
    logic signed [espc_pkg::NUM_W-1:0]    num_reg, num_next;
    logic [espc_pkg::NUM_W-1:0]           mag_reg, mag_next;
    logic                                 neg_reg, neg_next;
    logic                                 dead_reg, dead_next;
    logic                                 ovf_sat_reg, ovf_sat_next;
    logic                                 sat_reg, sat_next;
    logic [espc_pkg::QUOT_W-1:0]          duty_reg, duty_next;

    // Result register
    logic                  m_valid_reg, m_valid_next;
    espc_pkg::out_item_t   out_reg, out_next;

    // Unit connections
    logic                               div_start;
    espc_pkg::div_status_t              div_stat;
    logic [espc_pkg::QUOT_W-1:0]        div_quot;
    logic                               mul_start;
    logic [espc_pkg::MCAND_W-1:0]       mul_mcand;
    logic [espc_pkg::MPLIER_W-1:0]      mul_mplier;
    logic                               mul_done;
    logic [espc_pkg::PROD_W-1:0]        mul_prod;

    logic signed [espc_pkg::KNOB_W-1:0]    knob_diff;
    logic signed [espc_pkg::TGT_SUM_W-1:0] tgt_sum;
    logic [espc_pkg::PERIOD_W-1:0]         cmp;

    espc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .mag     (mag_reg),
        .status  (div_stat),
        .quot    (div_quot)
    );

    espc_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .mcand   (mul_mcand),
        .mplier  (mul_mplier),
        .done    (mul_done),
        .prod    (mul_prod)
    );

    assign s_ready = (state_reg == espc_pkg::ST_IDLE);

    // Knob delta and target sum feed the early steps
    assign knob_diff = knob_in_reg - last_knob_reg;
    assign tgt_sum   = espc_pkg::TGT_SUM_W'(target_reg) + espc_pkg::TGT_SUM_W'(delta_reg);

    // Compare value: dead zone first, then saturation, then the scaled duty
    always_comb begin
        if (dead_reg) begin
            cmp = '0;
        end else if (sat_reg) begin
            cmp = period_reg;
        end else begin
            cmp = mul_prod[espc_pkg::PROD_W-1:espc_pkg::QUOT_W];
        end
    end

    // Sequencer: next state, unit starts and datapath next values
    always_comb begin
        state_next      = state_reg;
        gain_next       = gain_reg;
        period_next     = period_reg;
        band_next       = band_reg;
        last_motor_next = last_motor_reg;
        last_knob_next  = last_knob_reg;
        speed_next      = speed_reg;
        target_next     = target_reg;
        knob_in_next    = knob_in_reg;
        delta_next      = delta_reg;
        prod_t_next     = prod_t_reg;
        prod_s_next     = prod_s_reg;
        spd_mag_next    = spd_mag_reg;
        num_next        = num_reg;
        mag_next        = mag_reg;
        neg_next        = neg_reg;
        dead_next       = dead_reg;
        ovf_sat_next    = ovf_sat_reg;
        sat_next        = sat_reg;
        duty_next       = duty_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        out_next        = out_reg;
        div_start       = 1'b0;
        mul_start       = 1'b0;
        mul_mcand       = duty_reg;
        mul_mplier      = period_reg;

        // Register writes
        if (cfg_we) begin
            case (cfg_index)
                espc_pkg::CFG_GAIN:   gain_next   = cfg_wdata[espc_pkg::GAIN_W-1:0];
                espc_pkg::CFG_PERIOD: period_next = cfg_wdata[espc_pkg::PERIOD_W-1:0];
                espc_pkg::CFG_BAND:   band_next   = cfg_wdata[espc_pkg::BAND_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            espc_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (s_data.command == espc_pkg::CMD_SPEED) begin
                        speed_next      = s_data.counter_value - last_motor_reg;
                        last_motor_next = s_data.counter_value;
                    end else begin
                        knob_in_next = s_data.counter_value[espc_pkg::KNOB_W-1:0];
                        state_next   = espc_pkg::ST_KNOB;
                    end
                end
            end
            espc_pkg::ST_KNOB: begin
                // Clamp the wrapped knob delta
                if (knob_diff > espc_pkg::KNOB_HI) begin
                    delta_next = espc_pkg::DELTA_MAX;
                end else if (knob_diff < espc_pkg::KNOB_LO) begin
                    delta_next = espc_pkg::DELTA_MIN;
                end else begin
                    delta_next = knob_diff[espc_pkg::DELTA_W-1:0];
                end
                last_knob_next = knob_in_reg;
                state_next     = espc_pkg::ST_TARGET;
            end
            espc_pkg::ST_TARGET: begin
                // Saturate the target at the 16-bit limits
                case (tgt_sum[espc_pkg::TGT_SUM_W-1:espc_pkg::TGT_SUM_W-2])
                    2'b01:   target_next = {1'b0, {(espc_pkg::KNOB_W-1){1'b1}}};
                    2'b10:   target_next = {1'b1, {(espc_pkg::KNOB_W-1){1'b0}}};
                    default: target_next = tgt_sum[espc_pkg::KNOB_W-1:0];
                endcase
                state_next = espc_pkg::ST_SCALE;
            end
            espc_pkg::ST_SCALE: begin
                prod_t_next  = espc_pkg::TP_W'(target_reg) * espc_pkg::FSC_MULT;
                prod_s_next  = espc_pkg::SP_W'(speed_reg) * espc_pkg::KS_MULT;
                spd_mag_next = speed_reg[espc_pkg::COUNT_W-1]
                             ? espc_pkg::COUNT_W'(-speed_reg)
                             : espc_pkg::COUNT_W'(speed_reg);
                state_next   = espc_pkg::ST_DIFF;
            end
            espc_pkg::ST_DIFF: begin
                num_next   = espc_pkg::NUM_W'(prod_t_reg) - espc_pkg::NUM_W'(prod_s_reg);
                dead_next  = (spd_mag_reg[espc_pkg::COUNT_W-1:espc_pkg::BAND_W] == '0)
                          && (spd_mag_reg[espc_pkg::BAND_W-1:0] < band_reg)
                          && (target_reg == '0);
                state_next = espc_pkg::ST_ABS;
            end
            espc_pkg::ST_ABS: begin
                neg_next   = num_reg[espc_pkg::NUM_W-1];
                mag_next   = num_reg[espc_pkg::NUM_W-1] ? espc_pkg::NUM_W'(-num_reg)
                                                        : espc_pkg::NUM_W'(num_reg);
                state_next = espc_pkg::ST_DIV_GO;
            end
            espc_pkg::ST_DIV_GO: begin
                div_start  = 1'b1;
                state_next = espc_pkg::ST_DIV;
            end
            espc_pkg::ST_DIV: begin
                // Error ready: start the gain multiply
                if (div_stat.done) begin
                    mul_start    = 1'b1;
                    mul_mcand    = div_quot;
                    mul_mplier   = espc_pkg::MPLIER_W'(gain_reg);
                    ovf_sat_next = div_stat.ovf && (gain_reg != '0);
                    state_next   = espc_pkg::ST_GAIN;
                end
            end
            espc_pkg::ST_GAIN: begin
                if (mul_done) begin
                    sat_next   = ovf_sat_reg
                              || (mul_prod[espc_pkg::PROD_W-1:espc_pkg::QUOT_W] != '0);
                    duty_next  = mul_prod[espc_pkg::QUOT_W-1:0];
                    state_next = espc_pkg::ST_PER_GO;
                end
            end
            espc_pkg::ST_PER_GO: begin
                mul_start  = 1'b1;
                state_next = espc_pkg::ST_PER;
            end
            espc_pkg::ST_PER: begin
                if (mul_done) begin
                    state_next = espc_pkg::ST_OUT;
                end
            end
            espc_pkg::ST_OUT: begin
                // Load the result once the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next           = 1'b1;
                    out_next.compare_value = cmp;
                    out_next.direction     = neg_reg;
                    out_next.target_steps  = target_reg;
                    state_next             = espc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = espc_pkg::ST_IDLE;
            end
        endcase
    end

    // Control, configuration and controller state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= espc_pkg::ST_IDLE;
            gain_reg       <= espc_pkg::GAIN_RESET;
            period_reg     <= espc_pkg::PERIOD_RESET;
            band_reg       <= espc_pkg::BAND_RESET;
            last_motor_reg <= '0;
            last_knob_reg  <= '0;
            speed_reg      <= '0;
            target_reg     <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            gain_reg       <= gain_next;
            period_reg     <= period_next;
            band_reg       <= band_next;
            last_motor_reg <= last_motor_next;
            last_knob_reg  <= last_knob_next;
            speed_reg      <= speed_next;
            target_reg     <= target_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Working values and result payload
    always_ff @(posedge aclk) begin
        knob_in_reg <= knob_in_next;
        delta_reg   <= delta_next;
        prod_t_reg  <= prod_t_next;
        prod_s_reg  <= prod_s_next;
        spd_mag_reg <= spd_mag_next;
        num_reg     <= num_next;
        mag_reg     <= mag_next;
        neg_reg     <= neg_next;
        dead_reg    <= dead_next;
        ovf_sat_reg <= ovf_sat_next;
        sat_reg     <= sat_next;
        duty_reg    <= duty_next;
        out_reg     <= out_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

// ----- sv/espc_div.sv -----
`timescale 1ns / 1ps
// Bit-serial restoring divider by the constant error denominator.
// Depends on espc_pkg; quotient above 32 bits is flagged through a sticky overflow.
module espc_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [espc_pkg::NUM_W-1:0]    mag,
    output espc_pkg::div_status_t         status,
    output logic [espc_pkg::QUOT_W-1:0]   quot
);

    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [espc_pkg::DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [espc_pkg::DIVD_W-1:0]     divd_reg, divd_next;
    logic [espc_pkg::REM_W-1:0]      rem_reg, rem_next;
    logic [espc_pkg::QUOT_W-1:0]     quot_reg, quot_next;
    logic                            ovf_reg, ovf_next;
    logic [espc_pkg::REM_W:0]        trial;
    logic                            take;

    // One dividend bit per cycle, MSB first
    always_comb begin
        trial     = {rem_reg, divd_reg[espc_pkg::DIVD_W-1]};
        take      = (trial >= espc_pkg::DENOM_V);
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        divd_next = divd_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        ovf_next  = ovf_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = espc_pkg::DIV_CNT_W'(espc_pkg::DIVD_W - 1);
            divd_next = {mag, espc_pkg::FRAC_W'(0)};
            rem_next  = '0;
            quot_next = '0;
            ovf_next  = 1'b0;
        end else if (busy_reg) begin
            divd_next = {divd_reg[espc_pkg::DIVD_W-2:0], 1'b0};
            rem_next  = take ? espc_pkg::REM_W'(trial - espc_pkg::DENOM_V)
                             : espc_pkg::REM_W'(trial);
            quot_next = {quot_reg[espc_pkg::QUOT_W-2:0], take};
            // Any bit pushed out of the top means the quotient needs more than 32 bits
            ovf_next  = ovf_reg | quot_reg[espc_pkg::QUOT_W-1];
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control flags under reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Advance the datapath shift registers
    always_ff @(posedge aclk) begin
        cnt_reg  <= cnt_next;
        divd_reg <= divd_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        ovf_reg  <= ovf_next;
    end

    assign status.done = done_reg;
    assign status.ovf  = ovf_reg;
    assign quot        = quot_reg;

endmodule

// ----- sv/espc_mul.sv -----
`timescale 1ns / 1ps
// Bit-serial shift-add multiplier, one multiplier bit per cycle, LSB first.
// Depends on espc_pkg; the product holds after done until the next start.
module espc_mul (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [espc_pkg::MCAND_W-1:0]   mcand,
    input  logic [espc_pkg::MPLIER_W-1:0]  mplier,
    output logic                           done,
    output logic [espc_pkg::PROD_W-1:0]    prod
);

    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [espc_pkg::MUL_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [espc_pkg::MCAND_W-1:0]    mcand_reg, mcand_next;
    logic [espc_pkg::PROD_W-1:0]     prod_reg, prod_next;
    logic [espc_pkg::MCAND_W:0]      sum;

    // Add the multiplicand into the upper half when the current bit is set, then shift
    always_comb begin
        sum = (espc_pkg::MCAND_W + 1)'(prod_reg[espc_pkg::PROD_W-1:espc_pkg::MPLIER_W])
            + (espc_pkg::MCAND_W + 1)'(prod_reg[0] ? mcand_reg : '0);
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        mcand_next = mcand_reg;
        prod_next  = prod_reg;
        if (start) begin
            busy_next  = 1'b1;
            cnt_next   = espc_pkg::MUL_CNT_W'(espc_pkg::MPLIER_W - 1);
            mcand_next = mcand;
            prod_next  = {espc_pkg::MCAND_W'(0), mplier};
        end else if (busy_reg) begin
            prod_next = {sum, prod_reg[espc_pkg::MPLIER_W-1:1]};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg   <= cnt_next;
        mcand_reg <= mcand_next;
        prod_reg  <= prod_next;
    end

    assign done = done_reg;
    assign prod = prod_reg;

endmodule

// ----- sv/espc_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the encoder speed P controller, bound to the top level.
// Depends on espc_pkg and encoder_speed_p_controller.
module espc_checker (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input espc_pkg::in_item_t    s_data,
    input logic                  m_valid,
    input logic                  m_ready,
    input espc_pkg::out_item_t   m_data
);

    // Reset empties the result register
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result still valid after reset");

    // A stalled result beat holds
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result beat changed");

    // An accepted control step closes the input
    a_control_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.command == espc_pkg::CMD_CONTROL) |=> !s_ready)
        else $error("input open right after a control step");

    // A speed sample never makes a result
    a_speed_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.command == espc_pkg::CMD_SPEED) && !m_valid
        |=> !m_valid)
        else $error("result after a speed sample");

    // Input reopens when a result is posted
    a_result_frees: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> s_ready)
        else $error("input still closed when result posted");

endmodule

bind encoder_speed_p_controller espc_checker u_espc_checker (.*);
